// ===== hdl/dstu_pkg.sv =====
// Package for the depth and stencil test unit.
// Holds register indexes, compare and stencil op codes, field offsets and shared types.
// It depends on nothing else.
package dstu_pkg;

  localparam int DEPTH_BITS_DEF   = 24;
  localparam int STENCIL_BITS_DEF = 8;
  localparam int CFG_DATA_W       = 28;
  localparam int CFG_INDEX_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_ENABLE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_FUNC    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRONT_STENCIL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_STENCIL  = 2'd3;

  localparam logic [CFG_DATA_W-1:0] STENCIL_RESET = 28'h007F800;

  localparam int ST_FUNC_LSB  = 0;
  localparam int ST_REF_LSB   = 3;
  localparam int ST_MASK_LSB  = 11;
  localparam int ST_FAIL_LSB  = 19;
  localparam int ST_ZFAIL_LSB = 22;
  localparam int ST_ZPASS_LSB = 25;

  typedef enum logic [2:0] {
    CMP_ALWAYS,
    CMP_NEVER,
    CMP_LT,
    CMP_LE,
    CMP_GT,
    CMP_GE,
    CMP_EQ,
    CMP_NE
  } cmp_func_t;

  typedef enum logic [2:0] {
    OP_KEEP,
    OP_ZERO,
    OP_REPLACE,
    OP_INCR,
    OP_INCR_WRAP,
    OP_DECR,
    OP_DECR_WRAP,
    OP_INVERT
  } stencil_op_t;

  typedef struct packed {
    stencil_op_t fail;
    stencil_op_t zfail;
    stencil_op_t zpass;
  } stencil_ops_t;

  typedef struct packed {
    logic sok;
    logic zok;
  } test_res_t;

  function automatic logic cmp_pass(cmp_func_t fn, logic lt, logic eq);
    logic r;
    case (fn)
      CMP_ALWAYS: r = 1'b1;
      CMP_NEVER:  r = 1'b0;
      CMP_LT:     r = lt;
      CMP_LE:     r = lt | eq;
      CMP_GT:     r = ~(lt | eq);
      CMP_GE:     r = ~lt;
      CMP_EQ:     r = eq;
      default:    r = ~eq;
    endcase
    return r;
  endfunction

  function automatic logic set_in_use(logic [CFG_DATA_W-1:0] s);
    return (s[ST_FUNC_LSB +: 3] != 3'(CMP_ALWAYS)) || (s[CFG_DATA_W-1:ST_FAIL_LSB] != '0);
  endfunction

endpackage

// ===== hdl/dstu_stencil_alu.sv =====
// Stencil update unit: picks the fail, zfail or zpass op from the test outcome
// and applies it to the stored stencil. Depends on dstu_pkg.
module dstu_stencil_alu
  import dstu_pkg::*;
#(
  parameter int STENCIL_BITS = STENCIL_BITS_DEF
) (
  input  test_res_t               res,
  input  stencil_ops_t            ops,
  input  logic [STENCIL_BITS-1:0] st_ref,
  input  logic [STENCIL_BITS-1:0] st_mask,
  input  logic [STENCIL_BITS-1:0] cur,
  output logic [STENCIL_BITS-1:0] result
);

  localparam logic [STENCIL_BITS-1:0] ST_FULL = '1;
  localparam logic [STENCIL_BITS-1:0] ST_ONE  = STENCIL_BITS'(1);

  stencil_op_t             op;
  logic [STENCIL_BITS-1:0] s;

  always_comb begin
    if (!res.sok) begin
      op = ops.fail;
    end else if (!res.zok) begin
      op = ops.zfail;
    end else begin
      op = ops.zpass;
    end
  end

  always_comb begin
    case (op)
      OP_KEEP:      s = cur;
      OP_ZERO:      s = '0;
      OP_REPLACE:   s = st_ref;
      OP_INCR:      s = (cur == ST_FULL) ? ST_FULL : cur + ST_ONE;
      OP_INCR_WRAP: s = cur + ST_ONE;
      OP_DECR:      s = (cur == '0) ? '0 : cur - ST_ONE;
      OP_DECR_WRAP: s = cur - ST_ONE;
      default:      s = ~cur;
    endcase
  end

  assign result = s & st_mask;

endmodule

// ===== hdl/depth_stencil_test_unit_top.sv =====
// Top level of the depth and stencil test unit: three-stage fragment pipeline.
// Depends on dstu_pkg and dstu_stencil_alu.
//
// Fragments arrive on the input channel (in_valid, in_stall) with their depth,
// facing flag and the depth and stencil read from the buffers. Each fragment
// gives one result on the output channel (out_valid, out_stall): the depth and
// stencil to write back, a write enable and the colour pass flag.
// Stage one selects the front or back stencil settings, stage two runs the
// stencil and depth compares, stage three applies the stencil op into the
// output register. A fragment is registered in stage one, then stage two, then
// the output register; one fragment is taken every cycle while the receiver
// does not stall.
// A stall holds the output register; empty stages ahead of it still fill, so
// in_stall rises only when all three stages hold a fragment.
// Reset empties the pipeline and loads the register defaults: depth test off,
// compare always, both stencil sets to compare always, mask all ones, keep.
// The configuration port writes one register per cycle with cfg_write high; the
// user must write it only while no fragment is in flight; unchecked by the block.
module depth_stencil_test_unit_top
  import dstu_pkg::*;
#(
  parameter int DEPTH_BITS   = DEPTH_BITS_DEF,
  parameter int STENCIL_BITS = STENCIL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [DEPTH_BITS-1:0]   frag_depth,
  input  logic                    front_facing,
  input  logic [DEPTH_BITS-1:0]   stored_depth,
  input  logic [STENCIL_BITS-1:0] stored_stencil,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DEPTH_BITS-1:0]   new_depth,
  output logic [STENCIL_BITS-1:0] new_stencil,
  output logic                    ds_write,
  output logic                    color_pass
);

  logic                  depth_enable;
  cmp_func_t             depth_func;
  logic [CFG_DATA_W-1:0] front_stencil;
  logic [CFG_DATA_W-1:0] back_stencil;

  logic                  adv1, adv2, adv3;
  logic [CFG_DATA_W-1:0] sel;

  logic                    s1_valid;
  logic [DEPTH_BITS-1:0]   s1_frag, s1_zbuf;
  logic [STENCIL_BITS-1:0] s1_cur, s1_ref, s1_mask;
  cmp_func_t               s1_func, s1_zfunc;
  stencil_ops_t            s1_ops;
  logic                    s1_zen, s1_in_use;

  logic                    s2_valid;
  logic [DEPTH_BITS-1:0]   s2_frag, s2_zbuf;
  logic [STENCIL_BITS-1:0] s2_cur, s2_ref, s2_mask;
  stencil_ops_t            s2_ops;
  test_res_t               s2_res;
  logic                    s2_zen, s2_in_use;

  test_res_t               res_next;
  logic [STENCIL_BITS-1:0] st_a, st_b;
  logic [STENCIL_BITS-1:0] stencil_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_enable  <= 1'b0;
      depth_func    <= CMP_ALWAYS;
      front_stencil <= STENCIL_RESET;
      back_stencil  <= STENCIL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEPTH_ENABLE:  depth_enable  <= cfg_data[0];
        REG_DEPTH_FUNC:    depth_func    <= cmp_func_t'(cfg_data[2:0]);
        REG_FRONT_STENCIL: front_stencil <= cfg_data;
        REG_BACK_STENCIL:  back_stencil  <= cfg_data;
      endcase
    end
  end

  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  assign sel = front_facing ? front_stencil : back_stencil;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_frag   <= frag_depth;
      s1_zbuf   <= stored_depth;
      s1_cur    <= stored_stencil;
      s1_func   <= cmp_func_t'(sel[ST_FUNC_LSB +: 3]);
      s1_ref    <= sel[ST_REF_LSB +: STENCIL_BITS];
      s1_mask   <= sel[ST_MASK_LSB +: STENCIL_BITS];
      s1_ops    <= '{fail:  stencil_op_t'(sel[ST_FAIL_LSB +: 3]),
                     zfail: stencil_op_t'(sel[ST_ZFAIL_LSB +: 3]),
                     zpass: stencil_op_t'(sel[ST_ZPASS_LSB +: 3])};
      s1_zfunc  <= depth_func;
      s1_zen    <= depth_enable;
      s1_in_use <= set_in_use(front_stencil) || set_in_use(back_stencil);
    end
  end

  assign st_a = s1_ref & s1_mask;
  assign st_b = s1_cur & s1_mask;

  always_comb begin
    res_next.sok = !s1_in_use || cmp_pass(s1_func, st_a < st_b, st_a == st_b);
    res_next.zok = !(s1_zen && res_next.sok) ||
                   cmp_pass(s1_zfunc, s1_frag < s1_zbuf, s1_frag == s1_zbuf);
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_frag   <= s1_frag;
      s2_zbuf   <= s1_zbuf;
      s2_cur    <= s1_cur;
      s2_ref    <= s1_ref;
      s2_mask   <= s1_mask;
      s2_ops    <= s1_ops;
      s2_res    <= res_next;
      s2_zen    <= s1_zen;
      s2_in_use <= s1_in_use;
    end
  end

  dstu_stencil_alu #(
    .STENCIL_BITS(STENCIL_BITS)
  ) u_alu (
    .res     (s2_res),
    .ops     (s2_ops),
    .st_ref  (s2_ref),
    .st_mask (s2_mask),
    .cur     (s2_cur),
    .result  (stencil_next)
  );

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      new_depth   <= (s2_zen && s2_res.sok && s2_res.zok) ? s2_frag : s2_zbuf;
      new_stencil <= stencil_next;
      ds_write    <= s2_zen || s2_in_use;
      color_pass  <= s2_res.sok && s2_res.zok;
    end
  end

endmodule

// ===== hdl/dstu_checker.sv =====
// Port-level checks for the depth and stencil test unit, bound to the top level.
// Depends on dstu_pkg and depth_stencil_test_unit_top.
module dstu_checker
  import dstu_pkg::*;
#(
  parameter int DEPTH_BITS   = DEPTH_BITS_DEF,
  parameter int STENCIL_BITS = STENCIL_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [DEPTH_BITS-1:0]   new_depth,
  input logic [STENCIL_BITS-1:0] new_stencil,
  input logic                    ds_write,
  input logic                    color_pass
);

  // A held result must stay until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(new_depth) && $stable(new_stencil) &&
                               $stable(ds_write) && $stable(color_pass))
    else $error("stalled result changed");

  // The pipeline only pushes back when every stage is full behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // With depth off and stencil unused both tests pass.
  a_idle_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ds_write |-> color_pass)
    else $error("fragment failed with both tests disabled");

endmodule

bind depth_stencil_test_unit_top dstu_checker #(
  .DEPTH_BITS(DEPTH_BITS),
  .STENCIL_BITS(STENCIL_BITS)
) u_dstu_checker (.*);
